// File: rtl/tawt_pkg.sv
// tawt_pkg: shared types and constants of the timed audio window table
// holds the slot record, status and command codes, register indexes
// used by timed_audio_window_table_unit
package tawt_pkg;

    localparam int TIME_W = 64;
    localparam int WORD_W = 32;
    localparam int RATE_W = 20;
    localparam int RET_W  = 63;
    localparam int BPF_W  = 7;
    localparam int STAT_W = 4;
    localparam int CFG_W  = 63;
    localparam int IDX_W  = 2;

    // shared multiply/divide unit widths
    localparam int MUL_W  = 30;
    localparam int PROD_W = TIME_W + MUL_W;
    localparam int REM_W  = 30;
    localparam int CNT_W  = 7;

    localparam logic [MUL_W-1:0] NS_PER_S = 30'd1000000000;
    localparam logic signed [TIME_W-1:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [RATE_W-1:0] RATE_RESET = 20'd48000;
    localparam logic [RET_W-1:0]  RET_RESET  = 63'd10000000000;
    localparam logic [BPF_W-1:0]  BPF_RESET  = 7'd4;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [IDX_W-1:0] REG_SAMPLE_RATE     = 2'd0;
    localparam logic [IDX_W-1:0] REG_RETENTION_NS    = 2'd1;
    localparam logic [IDX_W-1:0] REG_BYTES_PER_FRAME = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK         = 4'd0;
    localparam logic [STAT_W-1:0] ST_BAD_RANGE  = 4'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 4'd2;
    localparam logic [STAT_W-1:0] ST_MISALIGNED = 4'd3;
    localparam logic [STAT_W-1:0] ST_OVERLAP    = 4'd4;
    localparam logic [STAT_W-1:0] ST_FULL       = 4'd5;
    localparam logic [STAT_W-1:0] ST_NO_WINDOW  = 4'd6;
    localparam logic [STAT_W-1:0] ST_OUTSIDE    = 4'd7;
    localparam logic [STAT_W-1:0] ST_GAP        = 4'd8;
    localparam logic [STAT_W-1:0] ST_NO_SAMPLES = 4'd9;
    localparam logic [STAT_W-1:0] ST_OVERFLOW   = 4'd10;

    typedef struct packed {
        logic [TIME_W-1:0] start_ns;
        logic [TIME_W-1:0] end_ns;
        logic [WORD_W-1:0] samples;
        logic [WORD_W-1:0] handle;
    } t_entry;

endpackage

// File: rtl/timed_audio_window_table_unit.sv
// timed_audio_window_table_unit: start-sorted table of timed audio frame descriptors
// sequencer over a slot memory and one shared shift-add multiply / restoring divide unit
// depends on tawt_pkg
//
//  channel  direction  handshake                 payload
//  in       in         i_in_valid / o_in_stall   cmd, start_ns, end_ns, byte_count, data_handle
//  out      out        o_out_valid / i_out_stall status .. last, one port per field
//  cfg      in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one multiply-divide runs 30 multiply steps, then 94 divide steps
// an add runs one multiply-divide, then scans, shifts and moves slots one at a time
// a query runs up to 6 multiply-divides per covering slot
// no clearing pass after reset: slots above the held count are never read
// a result waits in the output register while stalled; the next transaction is taken meanwhile
module timed_audio_window_table_unit #(
    parameter int MAX_FRAMES = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_cmd,
    input  logic signed [tawt_pkg::TIME_W-1:0]    i_start_ns,
    input  logic signed [tawt_pkg::TIME_W-1:0]    i_end_ns,
    input  logic        [tawt_pkg::WORD_W-1:0]    i_byte_count,
    input  logic        [tawt_pkg::WORD_W-1:0]    i_data_handle,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic        [tawt_pkg::STAT_W-1:0]    o_status,
    output logic                                  o_is_segment,
    output logic        [tawt_pkg::WORD_W-1:0]    o_seg_handle,
    output logic        [tawt_pkg::WORD_W-1:0]    o_first_byte,
    output logic        [tawt_pkg::WORD_W-1:0]    o_end_byte,
    output logic signed [tawt_pkg::TIME_W-1:0]    o_exported_start,
    output logic signed [tawt_pkg::TIME_W-1:0]    o_exported_end,
    output logic                                  o_last,
    input  logic                                  i_cfg_we,
    input  logic        [tawt_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic        [tawt_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int IW = $clog2(MAX_FRAMES);
    localparam int TW = tawt_pkg::TIME_W;
    localparam int WW = tawt_pkg::WORD_W;
    localparam int MW = tawt_pkg::MUL_W;
    localparam int PW = tawt_pkg::PROD_W;
    localparam int RW = tawt_pkg::REM_W;
    localparam int NW = tawt_pkg::CNT_W;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_DIV, S_FINAL,
        A_START, A_DIV, A_REQ, A_SCAN, A_FULL, A_SH_REQ, A_SH_WR, A_INS, A_KEEP,
        A_PR_REQ, A_PR, A_MV_REQ, A_MV_WR,
        Q_START, Q_CHK0, Q_REQ, Q_SLOT, Q_C1, Q_C2, Q_B, Q_AB, Q_SEG, Q_TA, Q_TB, Q_FIN
    } t_state;

    t_state r_state, r_ret;

    tawt_pkg::t_entry mem [MAX_FRAMES];
    tawt_pkg::t_entry r_rd;

    logic [tawt_pkg::RATE_W-1:0] r_rate;
    logic [tawt_pkg::RET_W-1:0]  r_retention;
    logic [tawt_pkg::BPF_W-1:0]  r_bpf;

    logic [CW-1:0] r_count, r_i, r_j, r_p;
    logic signed [TW-1:0] r_newest, r_keep;

    logic                 r_cmd;
    logic signed [TW-1:0] r_qs, r_qe;
    logic [WW-1:0]        r_bytes, r_handle, r_smp;
    logic signed [TW-1:0] r_prev;
    logic [tawt_pkg::STAT_W-1:0] r_st;

    logic signed [TW-1:0] r_cursor, r_xs, r_xe, r_ts;
    logic                 r_have, r_selb;
    logic [TW-1:0]        r_delta, r_fl;
    logic [WW-1:0]        r_a, r_b;

    logic [TW-1:0] r_mx;
    logic [MW-1:0] r_mm, r_md;
    logic [PW-1:0] r_prod;
    logic [RW-1:0] r_rem;
    logic [NW-1:0] r_cnt;

    logic                 r_ov;
    logic [tawt_pkg::STAT_W-1:0] r_o_status;
    logic                 r_o_seg, r_o_last;
    logic [WW-1:0]        r_o_handle, r_o_fb, r_o_eb;
    logic signed [TW-1:0] r_o_xs, r_o_xe;

    logic [MW-1:0] rate_eff, bpf_eff;
    logic signed [TW-1:0] e_start, e_end, ret_s, keep_n, lim, max_mo, off_s;
    logic [TW-1:0] off_u, fl_inc, fl_min;
    logic [RW:0] rem_t, rem_s;
    logic        rem_ge;
    logic [WW+tawt_pkg::BPF_W-1:0] bpf_wide;
    logic [WW+tawt_pkg::BPF_W-1:0] fb_full, eb_full;
    logic out_free;
    logic out_load;
    logic rd_en, we;
    logic [IW-1:0] rd_a, wa;
    tawt_pkg::t_entry wd;

    assign rate_eff = (r_rate == '0) ? MW'(1) : MW'(r_rate);
    assign bpf_eff  = (r_bpf == '0) ? MW'(1) : MW'(r_bpf);
    assign e_start  = $signed(r_rd.start_ns);
    assign e_end    = $signed(r_rd.end_ns);
    assign ret_s    = $signed({1'b0, r_retention});
    assign keep_n   = (r_newest > ret_s) ? (r_newest - ret_s) : '0;
    assign lim      = (e_end < r_qe) ? e_end : r_qe;
    assign off_u    = r_prod[TW-1:0];
    assign off_s    = $signed(off_u);
    assign max_mo   = tawt_pkg::INT64_MAX - off_s;
    assign fl_inc   = (off_u != r_delta) ? (r_fl + TW'(1)) : r_fl;
    assign fl_min   = (fl_inc < {32'b0, r_rd.samples}) ? fl_inc : {32'b0, r_rd.samples};
    assign rem_t    = {r_rem, r_prod[PW-1]};
    assign rem_ge   = rem_t >= {1'b0, r_md};
    assign rem_s    = rem_t - {1'b0, r_md};
    assign bpf_wide = (WW + tawt_pkg::BPF_W)'(bpf_eff);
    assign fb_full  = r_a * bpf_wide;
    assign eb_full  = r_b * bpf_wide;
    assign out_free = !r_ov || !i_out_stall;
    assign out_load = ((r_state == S_FINAL) || (r_state == Q_SEG)) && out_free;

    // slot memory ports
    always_comb begin
        rd_en = 1'b0;
        rd_a  = '0;
        we    = 1'b0;
        wa    = '0;
        wd    = r_rd;
        unique case (r_state)
            A_REQ, A_PR_REQ: begin
                rd_en = 1'b1;
                rd_a  = r_i[IW-1:0];
            end
            Q_REQ: begin
                rd_en = 1'b1;
                rd_a  = r_i[IW-1:0];
            end
            A_SH_REQ: begin
                rd_en = 1'b1;
                rd_a  = IW'(r_j - CW'(1));
            end
            A_MV_REQ: begin
                rd_en = 1'b1;
                rd_a  = r_j[IW-1:0];
            end
            Q_START: begin
                rd_en = 1'b1;
                rd_a  = '0;
            end
            A_SH_WR: begin
                we = 1'b1;
                wa = r_j[IW-1:0];
            end
            A_INS: begin
                we = 1'b1;
                wa = r_p[IW-1:0];
                wd = '{start_ns: r_qs, end_ns: r_qe, samples: r_smp, handle: r_handle};
            end
            A_MV_WR: begin
                we = 1'b1;
                wa = IW'(r_j - r_p);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (rd_en) r_rd <= mem[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_count     <= '0;
            r_newest    <= '0;
            r_ov        <= 1'b0;
            r_rate      <= tawt_pkg::RATE_RESET;
            r_retention <= tawt_pkg::RET_RESET;
            r_bpf       <= tawt_pkg::BPF_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tawt_pkg::REG_SAMPLE_RATE:     r_rate      <= i_cfg_data[tawt_pkg::RATE_W-1:0];
                    tawt_pkg::REG_RETENTION_NS:    r_retention <= i_cfg_data;
                    tawt_pkg::REG_BYTES_PER_FRAME: r_bpf       <= i_cfg_data[tawt_pkg::BPF_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_cmd;
                        r_qs     <= i_start_ns;
                        r_qe     <= i_end_ns;
                        r_bytes  <= i_byte_count;
                        r_handle <= i_data_handle;
                        r_state  <= (i_cmd == tawt_pkg::CMD_QUERY) ? Q_START : A_START;
                    end
                end

                // shared unit: prod = x * m, then prod = prod / d, rem = prod % d
                S_MUL: begin
                    r_prod <= {r_prod[PW-2:0], 1'b0} + (r_mm[MW-1] ? {{MW{1'b0}}, r_mx} : '0);
                    r_mm   <= {r_mm[MW-2:0], 1'b0};
                    r_cnt  <= (r_cnt == NW'(MW - 1)) ? '0 : r_cnt + NW'(1);
                    if (r_cnt == NW'(MW - 1)) r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= rem_ge ? rem_s[RW-1:0] : rem_t[RW-1:0];
                    r_prod <= {r_prod[PW-2:0], rem_ge};
                    r_cnt  <= r_cnt + NW'(1);
                    if (r_cnt == NW'(PW - 1)) r_state <= r_ret;
                end

                S_FINAL: begin
                    if (out_free) begin
                        r_o_status <= r_st;
                        r_o_seg    <= 1'b0;
                        r_o_handle <= '0;
                        r_o_fb     <= '0;
                        r_o_eb     <= '0;
                        r_o_last   <= 1'b1;
                        if (r_st == tawt_pkg::ST_OK && r_cmd == tawt_pkg::CMD_QUERY) begin
                            r_o_xs <= r_xs;
                            r_o_xe <= r_xe;
                        end else begin
                            r_o_xs <= '0;
                            r_o_xe <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end

                // add transaction
                A_START: begin
                    if (!(r_qs < r_qe)) begin
                        r_st    <= tawt_pkg::ST_BAD_RANGE;
                        r_state <= S_FINAL;
                    end else if (r_bytes == '0) begin
                        r_st    <= tawt_pkg::ST_EMPTY;
                        r_state <= S_FINAL;
                    end else begin
                        r_mx    <= {32'b0, r_bytes};
                        r_mm    <= MW'(1);
                        r_md    <= bpf_eff;
                        r_prod  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_ret   <= A_DIV;
                        r_state <= S_MUL;
                    end
                end
                A_DIV: begin
                    if (r_rem != '0) begin
                        r_st    <= tawt_pkg::ST_MISALIGNED;
                        r_state <= S_FINAL;
                    end else begin
                        r_smp   <= r_prod[WW-1:0];
                        r_i     <= '0;
                        r_state <= A_REQ;
                    end
                end
                A_REQ: begin
                    if (r_i < r_count) begin
                        r_state <= A_SCAN;
                    end else if (r_i != '0 && r_prev > r_qs) begin
                        r_st    <= tawt_pkg::ST_OVERLAP;
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= A_FULL;
                    end
                end
                A_SCAN: begin
                    if (e_start < r_qs) begin
                        r_prev  <= e_end;
                        r_i     <= r_i + CW'(1);
                        r_state <= A_REQ;
                    end else if ((r_i != '0 && r_prev > r_qs) || r_qe > e_start) begin
                        r_st    <= tawt_pkg::ST_OVERLAP;
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= A_FULL;
                    end
                end
                A_FULL: begin
                    if (r_count >= CW'(MAX_FRAMES)) begin
                        r_st    <= tawt_pkg::ST_FULL;
                        r_state <= S_FINAL;
                    end else begin
                        r_p     <= r_i;
                        r_j     <= r_count;
                        r_state <= A_SH_REQ;
                    end
                end
                A_SH_REQ: begin
                    r_state <= (r_j > r_p) ? A_SH_WR : A_INS;
                end
                A_SH_WR: begin
                    r_j     <= r_j - CW'(1);
                    r_state <= A_SH_REQ;
                end
                A_INS: begin
                    r_count <= r_count + CW'(1);
                    if (r_qe > r_newest) r_newest <= r_qe;
                    r_state <= A_KEEP;
                end
                A_KEEP: begin
                    r_keep  <= keep_n;
                    r_i     <= '0;
                    r_state <= A_PR_REQ;
                end
                A_PR_REQ: begin
                    if (r_i < r_count) begin
                        r_state <= A_PR;
                    end else begin
                        r_p     <= r_i;
                        r_j     <= r_i;
                        r_state <= A_MV_REQ;
                    end
                end
                A_PR: begin
                    if (e_end <= r_keep) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= A_PR_REQ;
                    end else begin
                        r_p     <= r_i;
                        r_j     <= r_i;
                        r_state <= A_MV_REQ;
                    end
                end
                A_MV_REQ: begin
                    if (r_p != '0 && r_j < r_count) begin
                        r_state <= A_MV_WR;
                    end else begin
                        r_count <= r_count - r_p;
                        r_st    <= tawt_pkg::ST_OK;
                        r_state <= S_FINAL;
                    end
                end
                A_MV_WR: begin
                    r_j     <= r_j + CW'(1);
                    r_state <= A_MV_REQ;
                end

                // query transaction
                Q_START: begin
                    if (r_count == '0) begin
                        r_st    <= tawt_pkg::ST_NO_WINDOW;
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= Q_CHK0;
                    end
                end
                Q_CHK0: begin
                    if (!(r_qs < r_qe) || r_qs < e_start || r_qe > r_newest) begin
                        r_st    <= tawt_pkg::ST_OUTSIDE;
                        r_state <= S_FINAL;
                    end else begin
                        r_i      <= '0;
                        r_cursor <= r_qs;
                        r_have   <= 1'b0;
                        r_state  <= Q_REQ;
                    end
                end
                Q_REQ: begin
                    r_state <= (r_i < r_count) ? Q_SLOT : Q_FIN;
                end
                Q_SLOT: begin
                    if (e_end <= r_cursor) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= Q_REQ;
                    end else if (e_start >= r_qe) begin
                        r_state <= Q_FIN;
                    end else if (e_start > r_cursor) begin
                        r_st    <= tawt_pkg::ST_GAP;
                        r_state <= S_FINAL;
                    end else if (r_qs <= e_start) begin
                        r_a     <= '0;
                        r_state <= Q_B;
                    end else begin
                        r_selb  <= 1'b0;
                        r_delta <= r_qs - e_start;
                        r_mx    <= r_qs - e_start;
                        r_mm    <= rate_eff;
                        r_md    <= tawt_pkg::NS_PER_S;
                        r_prod  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_ret   <= Q_C1;
                        r_state <= S_MUL;
                    end
                end
                Q_C1: begin
                    r_fl    <= r_prod[TW-1:0];
                    r_mx    <= r_prod[TW-1:0];
                    r_mm    <= tawt_pkg::NS_PER_S;
                    r_md    <= rate_eff;
                    r_prod  <= '0;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_ret   <= Q_C2;
                    r_state <= S_MUL;
                end
                Q_C2: begin
                    if (r_selb) begin
                        r_b     <= fl_min[WW-1:0];
                        r_state <= Q_AB;
                    end else begin
                        r_a     <= fl_min[WW-1:0];
                        r_state <= Q_B;
                    end
                end
                Q_B: begin
                    if (r_qe >= e_end) begin
                        r_b     <= r_rd.samples;
                        r_state <= Q_AB;
                    end else if (r_qe <= e_start) begin
                        r_b     <= '0;
                        r_state <= Q_AB;
                    end else begin
                        r_selb  <= 1'b1;
                        r_delta <= r_qe - e_start;
                        r_mx    <= r_qe - e_start;
                        r_mm    <= rate_eff;
                        r_md    <= tawt_pkg::NS_PER_S;
                        r_prod  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_ret   <= Q_C1;
                        r_state <= S_MUL;
                    end
                end
                Q_AB: begin
                    if (r_b <= r_a) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= Q_REQ;
                    end else begin
                        r_state <= Q_SEG;
                    end
                end
                Q_SEG: begin
                    if (out_free) begin
                        r_o_status <= tawt_pkg::ST_OK;
                        r_o_seg    <= 1'b1;
                        r_o_handle <= r_rd.handle;
                        r_o_fb     <= fb_full[WW-1:0];
                        r_o_eb     <= eb_full[WW-1:0];
                        r_o_xs     <= '0;
                        r_o_xe     <= '0;
                        r_o_last   <= 1'b0;
                        r_mx       <= {32'b0, r_a};
                        r_mm       <= tawt_pkg::NS_PER_S;
                        r_md       <= rate_eff;
                        r_prod     <= '0;
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_ret      <= Q_TA;
                        r_state    <= S_MUL;
                    end
                end
                Q_TA: begin
                    if (e_start > max_mo) begin
                        r_st    <= tawt_pkg::ST_OVERFLOW;
                        r_state <= S_FINAL;
                    end else begin
                        r_ts    <= e_start + off_s;
                        r_mx    <= {32'b0, r_b};
                        r_mm    <= tawt_pkg::NS_PER_S;
                        r_md    <= rate_eff;
                        r_prod  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_ret   <= Q_TB;
                        r_state <= S_MUL;
                    end
                end
                Q_TB: begin
                    if (e_start > max_mo) begin
                        r_st    <= tawt_pkg::ST_OVERFLOW;
                        r_state <= S_FINAL;
                    end else if (r_have && r_ts > r_xe) begin
                        r_st    <= tawt_pkg::ST_GAP;
                        r_state <= S_FINAL;
                    end else begin
                        if (!r_have) r_xs <= r_ts;
                        r_xe    <= e_start + off_s;
                        r_have  <= 1'b1;
                        if (lim > r_cursor) r_cursor <= lim;
                        r_i     <= r_i + CW'(1);
                        r_state <= Q_REQ;
                    end
                end
                Q_FIN: begin
                    if (!r_have) r_st <= tawt_pkg::ST_NO_SAMPLES;
                    else if (r_cursor < r_qe) r_st <= tawt_pkg::ST_GAP;
                    else r_st <= tawt_pkg::ST_OK;
                    r_state <= S_FINAL;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_status         = r_o_status;
    assign o_is_segment     = r_o_seg;
    assign o_seg_handle     = r_o_handle;
    assign o_first_byte     = r_o_fb;
    assign o_end_byte       = r_o_eb;
    assign o_exported_start = r_o_xs;
    assign o_exported_end   = r_o_xe;
    assign o_last           = r_o_last;

endmodule

// File: test/tb_timed_audio_window_table_unit.sv
// tb_timed_audio_window_table_unit: self-checking bench for the timed audio window table
// a scoreboard class predicts every result transaction; tasks drive adds, queries and registers
// depends on tawt_pkg and timed_audio_window_table_unit
module tb_timed_audio_window_table_unit;

    typedef longint unsigned u64_t;
    localparam u64_t NS_S = 64'd1000000000;
    localparam int SLOTS = 32;
    localparam longint T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint T_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [tawt_pkg::STAT_W-1:0] status;
        logic                        is_segment;
        logic [tawt_pkg::WORD_W-1:0] handle;
        logic [tawt_pkg::WORD_W-1:0] lo_byte;
        logic [tawt_pkg::WORD_W-1:0] hi_byte;
        longint                      xs;
        longint                      xe;
        logic                        last;
    } t_result;

    class window_scoreboard;
        longint      fr_start[SLOTS];
        longint      fr_end[SLOTS];
        int unsigned fr_samples[SLOTS];
        int unsigned fr_handle[SLOTS];
        int          held;
        longint      newest;
        u64_t        rate;
        u64_t        retention;
        u64_t        bpf;
        t_result     pending_q[$];
        int          errors;

        function void clear();
            held = 0;
            newest = 0;
            rate = tawt_pkg::RATE_RESET;
            retention = tawt_pkg::RET_RESET;
            bpf = tawt_pkg::BPF_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [tawt_pkg::IDX_W-1:0] idx, u64_t data);
            case (idx)
                tawt_pkg::REG_SAMPLE_RATE:     rate = data[tawt_pkg::RATE_W-1:0];
                tawt_pkg::REG_RETENTION_NS:    retention = data[tawt_pkg::RET_W-1:0];
                tawt_pkg::REG_BYTES_PER_FRAME: bpf = data[tawt_pkg::BPF_W-1:0];
                default: ;
            endcase
        endfunction

        function u64_t rate_eff();
            return rate == 0 ? 1 : rate;
        endfunction

        function u64_t bpf_eff();
            return bpf == 0 ? 1 : bpf;
        endfunction

        function u64_t offset_of(u64_t idx);
            u64_t r;
            r = rate_eff();
            return (idx / r) * NS_S + (idx % r) * NS_S / r;
        endfunction

        function u64_t ceil_index(u64_t delta);
            u64_t r, fl;
            r = rate_eff();
            fl = (delta / NS_S) * r + (delta % NS_S) * r / NS_S;
            if (offset_of(fl) != delta) fl++;
            return fl;
        endfunction

        function u64_t index_from(int s, longint t, bit is_end);
            u64_t idx;
            if (is_end && t >= fr_end[s]) return fr_samples[s];
            if (t <= fr_start[s]) return 0;
            idx = ceil_index(u64_t'(t) - u64_t'(fr_start[s]));
            return idx < fr_samples[s] ? idx : u64_t'(fr_samples[s]);
        endfunction

        function bit time_of(int s, u64_t idx, output longint t);
            longint off;
            off = longint'(offset_of(idx));
            if (fr_start[s] > T_MAX - off) return 0;
            t = fr_start[s] + off;
            return 1;
        endfunction

        function void push(logic [tawt_pkg::STAT_W-1:0] st, logic seg, u64_t h, u64_t fb,
                           u64_t eb, longint xs, longint xe, logic lst);
            t_result r;
            r.status = st;
            r.is_segment = seg;
            r.handle = h[tawt_pkg::WORD_W-1:0];
            r.lo_byte = fb[tawt_pkg::WORD_W-1:0];
            r.hi_byte = eb[tawt_pkg::WORD_W-1:0];
            r.xs = xs;
            r.xe = xe;
            r.last = lst;
            pending_q.push_back(r);
        endfunction

        function logic [tawt_pkg::STAT_W-1:0] insert_frame(longint fs, longint fe,
                                                           int unsigned bytes, int unsigned h);
            int p;
            int i;
            longint keep_from;
            longint rt;
            if (!(fs < fe)) return tawt_pkg::ST_BAD_RANGE;
            if (bytes == 0) return tawt_pkg::ST_EMPTY;
            if (u64_t'(bytes) % bpf_eff() != 0) return tawt_pkg::ST_MISALIGNED;
            p = 0;
            while (p < held && fr_start[p] < fs) p++;
            if (p > 0 && fr_end[p-1] > fs) return tawt_pkg::ST_OVERLAP;
            if (p < held && fe > fr_start[p]) return tawt_pkg::ST_OVERLAP;
            if (held >= SLOTS) return tawt_pkg::ST_FULL;
            for (i = held; i > p; i--) begin
                fr_start[i] = fr_start[i-1];
                fr_end[i] = fr_end[i-1];
                fr_samples[i] = fr_samples[i-1];
                fr_handle[i] = fr_handle[i-1];
            end
            fr_start[p] = fs;
            fr_end[p] = fe;
            fr_samples[p] = int'(u64_t'(bytes) / bpf_eff());
            fr_handle[p] = h;
            held++;
            if (fe > newest) newest = fe;
            rt = longint'(retention);
            keep_from = newest > rt ? newest - rt : 0;
            p = 0;
            while (p < held && fr_end[p] <= keep_from) p++;
            if (p > 0) begin
                for (i = p; i < held; i++) begin
                    fr_start[i-p] = fr_start[i];
                    fr_end[i-p] = fr_end[i];
                    fr_samples[i-p] = fr_samples[i];
                    fr_handle[i-p] = fr_handle[i];
                end
                held -= p;
            end
            return tawt_pkg::ST_OK;
        endfunction

        function void export_range(longint qs, longint qe);
            int s;
            bit have;
            longint cursor, xs, xe, ts, te, lim;
            u64_t a, b;
            have = 0;
            cursor = qs;
            xs = 0;
            xe = 0;
            if (held == 0) begin
                push(tawt_pkg::ST_NO_WINDOW, 0, 0, 0, 0, 0, 0, 1);
                return;
            end
            if (!(qs < qe) || qs < fr_start[0] || qe > newest) begin
                push(tawt_pkg::ST_OUTSIDE, 0, 0, 0, 0, 0, 0, 1);
                return;
            end
            for (s = 0; s < held; s++) begin
                if (fr_end[s] <= cursor) continue;
                if (fr_start[s] >= qe) break;
                if (fr_start[s] > cursor) begin
                    push(tawt_pkg::ST_GAP, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
                a = index_from(s, qs, 0);
                b = index_from(s, qe, 1);
                if (b <= a) continue;
                push(tawt_pkg::ST_OK, 1, fr_handle[s], a * bpf_eff(), b * bpf_eff(), 0, 0, 0);
                if (!time_of(s, a, ts) || !time_of(s, b, te)) begin
                    push(tawt_pkg::ST_OVERFLOW, 0, 0, 0, 0, 0, 0, 1);
                    return;
                end
                if (!have) begin
                    xs = ts;
                    xe = te;
                    have = 1;
                end else begin
                    if (ts > xe) begin
                        push(tawt_pkg::ST_GAP, 0, 0, 0, 0, 0, 0, 1);
                        return;
                    end
                    xe = te;
                end
                lim = fr_end[s] < qe ? fr_end[s] : qe;
                if (lim > cursor) cursor = lim;
            end
            if (!have) push(tawt_pkg::ST_NO_SAMPLES, 0, 0, 0, 0, 0, 0, 1);
            else if (cursor < qe) push(tawt_pkg::ST_GAP, 0, 0, 0, 0, 0, 0, 1);
            else push(tawt_pkg::ST_OK, 0, 0, 0, 0, xs, xe, 1);
        endfunction

        function void note_input(logic cmd, longint s, longint e, int unsigned bc,
                                 int unsigned h);
            if (cmd == tawt_pkg::CMD_ADD) push(insert_frame(s, e, bc, h), 0, 0, 0, 0, 0, 0, 1);
            else export_range(s, e);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                $error("result transaction with nothing expected, status %0d", got.status);
                errors++;
                return;
            end
            want = pending_q[0];
            pending_q.delete(0);
            if (got.status !== want.status) begin
                $error("status exp %0d got %0d", want.status, got.status);
                errors++;
            end
            if (got.is_segment !== want.is_segment) begin
                $error("is_segment exp %0b got %0b", want.is_segment, got.is_segment);
                errors++;
            end
            if (got.handle !== want.handle) begin
                $error("seg_handle exp %0h got %0h", want.handle, got.handle);
                errors++;
            end
            if (got.lo_byte !== want.lo_byte) begin
                $error("first_byte exp %0h got %0h", want.lo_byte, got.lo_byte);
                errors++;
            end
            if (got.hi_byte !== want.hi_byte) begin
                $error("end_byte exp %0h got %0h", want.hi_byte, got.hi_byte);
                errors++;
            end
            if (got.xs !== want.xs) begin
                $error("exported_start exp %0d got %0d", want.xs, got.xs);
                errors++;
            end
            if (got.xe !== want.xe) begin
                $error("exported_end exp %0d got %0d", want.xe, got.xe);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last exp %0b got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_stall;
    logic                               i_cmd = tawt_pkg::CMD_ADD;
    logic signed [tawt_pkg::TIME_W-1:0] i_start_ns = '0;
    logic signed [tawt_pkg::TIME_W-1:0] i_end_ns = '0;
    logic [tawt_pkg::WORD_W-1:0]        i_byte_count = '0;
    logic [tawt_pkg::WORD_W-1:0]        i_data_handle = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    logic [tawt_pkg::STAT_W-1:0]        o_status;
    logic                               o_is_segment;
    logic [tawt_pkg::WORD_W-1:0]        o_seg_handle;
    logic [tawt_pkg::WORD_W-1:0]        o_first_byte;
    logic [tawt_pkg::WORD_W-1:0]        o_end_byte;
    logic signed [tawt_pkg::TIME_W-1:0] o_exported_start;
    logic signed [tawt_pkg::TIME_W-1:0] o_exported_end;
    logic                               o_last;
    logic                               i_cfg_we = 1'b0;
    logic [tawt_pkg::IDX_W-1:0]         i_cfg_idx = '0;
    logic [tawt_pkg::CFG_W-1:0]         i_cfg_data = '0;

    window_scoreboard sb = new();
    bit calm = 1'b0;
    longint cursor;

    timed_audio_window_table_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #1000000000;
        $display("== FAIL ==");
        $finish;
    end

    // result side: check accepted transactions, stall at random
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            r.status = o_status;
            r.is_segment = o_is_segment;
            r.handle = o_seg_handle;
            r.lo_byte = o_first_byte;
            r.hi_byte = o_end_byte;
            r.xs = o_exported_start;
            r.xe = o_exported_end;
            r.last = o_last;
            sb.check_result(r);
        end
        i_out_stall <= !calm && ($urandom_range(0, 99) < 19);
    end

    task automatic send(logic cmd, longint s, longint e, int unsigned bc, int unsigned h);
        if (!calm && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_start_ns <= s;
        i_end_ns <= e;
        i_byte_count <= bc;
        i_data_handle <= h;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(cmd, s, e, bc, h);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tawt_pkg::IDX_W-1:0] idx, u64_t data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[tawt_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic set_all(u64_t rate, u64_t ret, u64_t bpf);
        wait_idle();
        write_reg(tawt_pkg::REG_SAMPLE_RATE, rate);
        write_reg(tawt_pkg::REG_RETENTION_NS, ret);
        write_reg(tawt_pkg::REG_BYTES_PER_FRAME, bpf);
    endtask

    task automatic random_add();
        int unsigned n;
        longint dur, s, jump;
        int unsigned bc;
        n = $urandom_range(1, 64);
        dur = longint'(sb.offset_of(n));
        if ($urandom_range(0, 3) == 0) dur += $urandom_range(1, 1000);
        if (dur < 1) dur = 1;
        s = cursor;
        case ($urandom_range(0, 19))
            0, 1: s = cursor + $urandom_range(1, 5000000);
            2: s = cursor - $urandom_range(1, 1000);
            3, 4: begin
                jump = longint'(sb.retention / 3);
                if (jump > 64'd1099511627776) jump = 64'd1099511627776;
                s = cursor + jump + 1;
            end
            default: ;
        endcase
        bc = n * int'(sb.bpf_eff());
        if ($urandom_range(0, 19) == 0) bc += 1;
        send(tawt_pkg::CMD_ADD, s, s + dur, bc, $urandom);
        if (s >= cursor) cursor = s + dur;
    endtask

    task automatic random_query();
        int k, j;
        longint qs, qe, span;
        if (sb.held == 0) begin
            random_add();
            return;
        end
        k = $urandom_range(0, sb.held - 1);
        j = k + $urandom_range(0, 3);
        if (j >= sb.held) j = sb.held - 1;
        span = sb.fr_end[k] - sb.fr_start[k];
        if (span > 64'd2000000000) span = 2000000000;
        qs = sb.fr_start[k] + ($urandom_range(0, 1) ? 0 : $urandom_range(0, int'(span) - 1));
        span = sb.fr_end[j] - sb.fr_start[j];
        if (span > 64'd2000000000) span = 2000000000;
        qe = sb.fr_start[j] + $urandom_range(1, int'(span));
        if ($urandom_range(0, 9) == 0) qe = sb.newest;
        if ($urandom_range(0, 19) == 0) qs -= 1;
        if (qe <= qs) qe = qs + 1;
        send(tawt_pkg::CMD_QUERY, qs, qe, $urandom, $urandom);
    endtask

    task automatic random_noise();
        longint s, e, t;
        s = {$urandom, $urandom};
        e = {$urandom, $urandom};
        // adds are kept invalid so that newest end is not thrown far away
        if ($urandom_range(0, 1) == 0) begin
            if (s < e) begin
                t = s;
                s = e;
                e = t;
            end
            send(tawt_pkg::CMD_ADD, s, e, $urandom, $urandom);
        end else begin
            send(tawt_pkg::CMD_QUERY, s, e, $urandom, $urandom);
        end
    endtask

    task automatic random_phase(int count);
        int i, pick;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) random_noise();
            else if (pick < 65) random_add();
            else random_query();
        end
    endtask

    initial begin
        longint t0;
        sb.clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        t0 = 64'sd1700000000000000000;

        // directed transactions at reset register values
        send(tawt_pkg::CMD_QUERY, t0, t0 + 1, 0, 0);
        send(tawt_pkg::CMD_ADD, t0, t0, 4, 1);
        send(tawt_pkg::CMD_ADD, t0, t0 + 10000000, 0, 1);
        send(tawt_pkg::CMD_ADD, t0, t0 + 10000000, 6, 1);
        send(tawt_pkg::CMD_ADD, t0, t0 + 10000000, 1920, 32'h0000_0000);
        send(tawt_pkg::CMD_ADD, t0 + 10000000, t0 + 20000000, 1920, 32'hFFFF_FFFF);
        send(tawt_pkg::CMD_ADD, t0 + 5000000, t0 + 8000000, 4, 2);
        send(tawt_pkg::CMD_ADD, t0 - 5000000, t0 + 1000000, 4, 3);
        send(tawt_pkg::CMD_QUERY, t0 - 1, t0 + 1000, 0, 0);
        send(tawt_pkg::CMD_QUERY, t0 + 1000, t0 + 1000, 0, 0);
        send(tawt_pkg::CMD_QUERY, t0 + 1000000, t0 + 15000000, 0, 0);
        send(tawt_pkg::CMD_ADD, t0 + 30000000, t0 + 40000000, 32'hFFFF_FFFC, 4);
        send(tawt_pkg::CMD_QUERY, t0, t0 + 35000000, 0, 0);
        send(tawt_pkg::CMD_QUERY, t0 + 1, t0 + 2, 0, 0);
        send(tawt_pkg::CMD_QUERY, t0 + 31000000, t0 + 40000000, 0, 0);
        send(tawt_pkg::CMD_ADD, T_MIN, T_MIN + 1000, 4, 5);
        send(tawt_pkg::CMD_ADD, t0 + 50000000, T_MIN, 4, 6);
        cursor = t0 + 50000000;

        calm = 1'b1;
        random_phase(70);
        calm = 1'b0;
        random_phase(20);
        set_all(768000, 64'h7FFF_FFFF_FFFF_FFFF, 64);
        random_phase(50);
        set_all(1, 1, 1);
        random_phase(50);
        set_all(0, 3000000000, 0);
        random_phase(50);
        set_all(44100, 500000000, 6);
        random_phase(50);
        set_all($urandom_range(1, 768000), $urandom_range(1000000, 2000000000),
                $urandom_range(1, 64));
        random_phase(50);

        // extremes near the top of the time range, retention back to reset value
        set_all(48000, 10000000000, 4);
        send(tawt_pkg::CMD_ADD, T_MAX - 2000000, T_MAX, 800, 7);
        send(tawt_pkg::CMD_QUERY, T_MAX - 2000000, T_MAX, 0, 0);
        send(tawt_pkg::CMD_QUERY, T_MAX - 1000000, T_MAX - 500000, 0, 0);

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
